// ===== hw/rtl/block_bitmap_allocator_unit_macros.svh =====
// assertion macros for the block bitmap allocator
// included by the modules that carry concurrent checks, no other dependencies
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("bba check failed");
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bba check failed");
`else
`define BBA_ASSERT(lbl, clk, rst_n, cond)
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bba_pkg.sv =====
// shared types and constants of the block bitmap allocator
// no dependencies
package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    localparam int ID_W     = 12;
    localparam int COUNT_W  = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] TOTAL_RESET = 13'd4096;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_MARK  = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_NO_SPACE = 2'd1,
        STAT_REFUSED  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_COUNT = 2'd0,
        CFG_FIRST_DATA  = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] block_id;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0]    result_block;
        status_t            status;
        logic [COUNT_W-1:0] free_blocks;
    } out_t;

    typedef struct packed {
        logic [COUNT_W-1:0] block_count;
        logic [COUNT_W-1:0] first_data_block;
    } cfg_t;

endpackage

// ===== hw/rtl/bba_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/bba_find.sv =====
// first clear bit finder over one bitmap word, limited to the low avail bits
// no dependencies
module bba_find #(
    parameter int WORD_BITS = 32,
    localparam int BIT_W = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [BIT_W:0]       avail,
    output logic                 found,
    output logic [BIT_W-1:0]     idx
);

    // walk from the top so the lowest clear bit wins
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i] && (i < int'(avail))) begin
                found = 1'b1;
                idx   = BIT_W'(i);
            end
        end
    end

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// sequencer of the block bitmap allocator: clearing pass, scan, read-modify-write
// depends on bba_pkg and the assertion macro header
`include "block_bitmap_allocator_unit_macros.svh"
module bba_ctrl
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF,
    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS,
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
    localparam int BIT_W     = $clog2(WORD_BITS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    output logic                 ram_we,
    output logic [ADDR_W-1:0]    ram_waddr,
    output logic [WORD_BITS-1:0] ram_wdata,
    output logic [ADDR_W-1:0]    ram_raddr,
    input  logic [WORD_BITS-1:0] ram_rdata,
    output logic [BIT_W:0]       find_avail,
    input  logic                 find_found,
    input  logic [BIT_W-1:0]     find_idx
);

    localparam int LIM_W     = $clog2(MAX_BLOCKS + 1);
    localparam int BASE_W    = LIM_W + 1;
    localparam int DIV_SHIFT = 18;
    localparam int DIV_MUL   = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int MUL_W     = ID_W + DIV_SHIFT;
    localparam int REM_W     = COUNT_W + BIT_W + 1;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DIV    = 6'b000100,
        S_SCAN   = 6'b001000,
        S_MODIFY = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [COUNT_W-1:0]  q_reg, q_next;
    logic [ADDR_W-1:0]   word_reg, word_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [LIM_W-1:0]    limit_reg, limit_next;
    status_t             status_reg, status_next;
    logic [ID_W-1:0]     res_reg, res_next;
    logic [COUNT_W-1:0]  used_reg, used_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic                m_valid_reg, m_valid_next;
    out_t                m_data_reg, m_data_next;

    logic [MUL_W-1:0]    div_prod;
    logic [REM_W-1:0]    rem_prod;
    logic [REM_W-1:0]    rem_raw;
    logic [COUNT_W-1:0]  q_fix;
    logic [REM_W-1:0]    rem_fix;
    logic [LIM_W-1:0]    lim;
    logic [BASE_W-1:0]   scan_left;
    logic [BASE_W-1:0]   base_step;
    logic [WORD_BITS-1:0] bit_mask;
    logic [COUNT_W-1:0]  used_up, used_dn;
    logic [COUNT_W-1:0]  free_now;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        // quotient by reciprocal, exact for 12-bit ids, remainder fixed up next cycle
        div_prod = MUL_W'(s_data.block_id) * MUL_W'(DIV_MUL);
        rem_prod = REM_W'(q_reg) * REM_W'(WORD_BITS);
        rem_raw  = REM_W'(id_reg) - rem_prod;
        if (rem_raw >= REM_W'(WORD_BITS)) begin
            q_fix   = q_reg + 1'b1;
            rem_fix = rem_raw - REM_W'(WORD_BITS);
        end else begin
            q_fix   = q_reg;
            rem_fix = rem_raw;
        end

        if (32'(cfg.block_count) > MAX_BLOCKS) begin
            lim = LIM_W'(MAX_BLOCKS);
        end else begin
            lim = LIM_W'(cfg.block_count);
        end

        scan_left = BASE_W'(limit_reg) - base_reg;
        if (scan_left >= BASE_W'(WORD_BITS)) begin
            find_avail = (BIT_W + 1)'(WORD_BITS);
        end else begin
            find_avail = (BIT_W + 1)'(scan_left);
        end
        base_step = base_reg + BASE_W'(WORD_BITS);

        used_up  = (used_reg == COUNT_MAX) ? used_reg : used_reg + 1'b1;
        used_dn  = (used_reg == '0) ? used_reg : used_reg - 1'b1;
        free_now = (cfg.block_count > used_reg) ? cfg.block_count - used_reg : '0;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        q_next       = q_reg;
        word_next    = word_reg;
        bit_next     = bit_reg;
        base_next    = base_reg;
        limit_next   = limit_reg;
        status_next  = status_reg;
        res_next     = res_reg;
        used_next    = used_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = word_reg;
        ram_wdata = ram_rdata;
        ram_raddr = ADDR_W'(word_reg + 1'b1);
        bit_mask  = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == ADDR_W'(MAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                ram_raddr = '0;
                if (s_valid) begin
                    op_next     = s_data.op;
                    id_next     = s_data.block_id;
                    res_next    = s_data.block_id;
                    status_next = STAT_DONE;
                    q_next      = COUNT_W'(div_prod >> DIV_SHIFT);
                    state_next  = S_DONE;
                    unique case (s_data.op)
                        OP_ALLOC: begin
                            res_next = '0;
                            if (lim == '0) begin
                                status_next = STAT_NO_SPACE;
                            end else begin
                                base_next  = '0;
                                word_next  = '0;
                                limit_next = lim;
                                state_next = S_SCAN;
                            end
                        end
                        OP_MARK: begin
                            if (int'(s_data.block_id) < MAX_BLOCKS) begin
                                state_next = S_DIV;
                            end
                        end
                        OP_FREE: begin
                            if (COUNT_W'(s_data.block_id) < cfg.first_data_block) begin
                                status_next = STAT_REFUSED;
                            end else if (int'(s_data.block_id) < MAX_BLOCKS) begin
                                state_next = S_DIV;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                word_next  = q_fix[ADDR_W-1:0];
                bit_next   = rem_fix[BIT_W-1:0];
                ram_raddr  = q_fix[ADDR_W-1:0];
                state_next = S_MODIFY;
            end
            S_MODIFY: begin
                bit_mask = WORD_BITS'(1) << bit_reg;
                ram_we   = 1'b1;
                if (op_reg == OP_MARK) begin
                    ram_wdata = ram_rdata | bit_mask;
                    used_next = used_up;
                end else begin
                    ram_wdata = ram_rdata & ~bit_mask;
                    used_next = used_dn;
                end
                state_next = S_DONE;
            end
            S_SCAN: begin
                // read data holds word_reg, the next word is already addressed
                if (find_found) begin
                    bit_mask   = WORD_BITS'(1) << find_idx;
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata | bit_mask;
                    res_next   = ID_W'(base_reg + BASE_W'(find_idx));
                    used_next  = used_up;
                    state_next = S_DONE;
                end else if (base_step >= BASE_W'(limit_reg)) begin
                    status_next = STAT_NO_SPACE;
                    state_next  = S_DONE;
                end else begin
                    base_next = base_step;
                    word_next = word_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.result_block = res_reg;
                    m_data_next.status       = status_reg;
                    m_data_next.free_blocks  = free_now;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            used_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        q_reg      <= q_next;
        word_reg   <= word_next;
        bit_reg    <= bit_next;
        base_reg   <= base_next;
        limit_reg  <= limit_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    `BBA_ASSERT_IMP(a_we_state, aclk, aresetn, ram_we, state_reg == S_CLEAR || state_reg == S_SCAN || state_reg == S_MODIFY)
    `BBA_ASSERT_IMP(a_result_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == S_DONE))
    `BBA_ASSERT_IMP(a_found_in_range, aclk, aresetn, state_reg == S_SCAN && find_found, (base_reg + BASE_W'(find_idx)) < BASE_W'(limit_reg))
    `BBA_ASSERT_IMP(a_count_step, aclk, aresetn, $past(aresetn), used_reg == $past(used_reg) || used_reg == $past(used_reg) + 13'd1 || used_reg == $past(used_reg) - 13'd1)

endmodule

// ===== hw/rtl/block_bitmap_allocator_unit.sv =====
// Block bitmap allocator: one usage bit per block in an on-chip ram of MAX_BLOCKS / WORD_BITS
// words (rounded up), plus a saturating used-block count. After reset a clearing pass writes
// one ram word a cycle with s_ready low; configuration writes are taken at any time. One item
// is in work at a time. An allocate scans the bitmap one ram word per cycle up to the
// configured block count and stops at the first free block, or reports no space at the end.
// Mark-used and free are a read-modify-write of one word; a refused free or an unused op
// writes no ram word. A finished result sits in the output register while the next request
// is taken.
// depends on bba_pkg, bba_ram, bba_find, bba_ctrl
module block_bitmap_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);

    logic [COUNT_W-1:0]   total_reg, total_next;
    logic [COUNT_W-1:0]   first_reg, first_next;
    cfg_t                 cfg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [BIT_W:0]       find_avail;
    logic                 find_found;
    logic [BIT_W-1:0]     find_idx;

    always_comb begin
        total_next = total_reg;
        first_next = first_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BLOCK_COUNT: total_next = cfg_wdata;
                CFG_FIRST_DATA:  first_next = cfg_wdata;
                default: begin
                    total_next = total_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= TOTAL_RESET;
            first_reg <= '0;
        end else begin
            total_reg <= total_next;
            first_reg <= first_next;
        end
    end

    assign cfg.block_count      = total_reg;
    assign cfg.first_data_block = first_reg;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_find #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .word  (ram_rdata),
        .avail (find_avail),
        .found (find_found),
        .idx   (find_idx)
    );

    bba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .find_avail (find_avail),
        .find_found (find_found),
        .find_idx   (find_idx)
    );

endmodule
